FILE: src/tun_pkg.sv
// Package for the triangle unit normal pipeline: widths, shared vector type.
// No dependencies.
`default_nettype none
package tun_pkg;
   localparam int CoordW = 24;
   localparam int EdgeW  = 25;
   localparam int CrossW = 51;
   localparam int MagW   = 31;
   localparam int SumW   = 64;
   localparam int RootW  = 32;
   localparam int NormW  = 16;
   localparam int SqrtSteps = 32;
   localparam int QuotW  = 17;
   localparam int DivSteps  = 17;

   typedef struct packed {
      logic [2:0]             neg;
      logic                   degen;
      logic [2:0][MagW-1:0]   mag;
   } vec_type;
endpackage
`default_nettype wire

FILE: src/tun_sqrt_cell.sv
// One restoring square root step; the normalized vector rides along beside it.
// Uses tun_pkg.
`default_nettype none
module tun_sqrt_cell import tun_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [SumW-1:0]   rem_i,
   input  wire logic [SumW-1:0]   op_i,
   input  wire logic [RootW-1:0]  root_i,
   input  wire vec_type           vec_i,
   output logic      [SumW-1:0]   rem_o,
   output logic      [SumW-1:0]   op_o,
   output logic      [RootW-1:0]  root_o,
   output vec_type                vec_o
);
   logic [SumW+1:0] rem_in;
   logic [SumW+1:0] trial;
   logic [SumW-1:0] rem_ff;
   logic [SumW-1:0] op_ff;
   logic [RootW-1:0] root_ff;
   vec_type vec_ff;

   // bring down two radicand bits, try (root<<2)|1
   always_comb begin
      rem_in = {rem_i, op_i[SumW-1 -: 2]};
      trial  = {root_i, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (rem_in >= trial) begin
            rem_ff  <= SumW'(rem_in - trial);
            root_ff <= {root_i[RootW-2:0], 1'b1};
         end else begin
            rem_ff  <= SumW'(rem_in);
            root_ff <= {root_i[RootW-2:0], 1'b0};
         end
         op_ff  <= {op_i[SumW-3:0], 2'b00};
         vec_ff <= vec_i;
      end
   end

   assign rem_o  = rem_ff;
   assign op_o   = op_ff;
   assign root_o = root_ff;
   assign vec_o  = vec_ff;
endmodule
`default_nettype wire

FILE: src/tun_div_cell.sv
// One restoring divide step on three components sharing a divisor.
// Uses tun_pkg.
`default_nettype none
module tun_div_cell import tun_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [RootW-1:0]      len_i,
   input  wire logic [2:0][RootW:0]   rem_i,
   input  wire logic [2:0][QuotW-1:0] q_i,
   input  wire logic [2:0]            neg_i,
   input  wire logic                  degen_i,
   output logic      [RootW-1:0]      len_o,
   output logic      [2:0][RootW:0]   rem_o,
   output logic      [2:0][QuotW-1:0] q_o,
   output logic      [2:0]            neg_o,
   output logic                       degen_o
);
   logic [RootW-1:0] len_ff;
   logic [2:0][RootW:0] rem_ff;
   logic [2:0][QuotW-1:0] q_ff;
   logic [2:0] neg_ff;
   logic degen_ff;
   logic [2:0][RootW+1:0] sh;

   always_comb begin
      for (int i = 0; i < 3; i++) sh[i] = {rem_i[i], q_i[i][QuotW-1]};
   end

   // the quotient MSB carries the next dividend bit into the remainder
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (sh[i] >= {2'b00, len_i}) begin
               rem_ff[i] <= (RootW+1)'(sh[i] - {2'b00, len_i});
               q_ff[i]   <= {q_i[i][QuotW-2:0], 1'b1};
            end else begin
               rem_ff[i] <= (RootW+1)'(sh[i]);
               q_ff[i]   <= {q_i[i][QuotW-2:0], 1'b0};
            end
         end
         len_ff   <= len_i;
         neg_ff   <= neg_i;
         degen_ff <= degen_i;
      end
   end

   assign len_o   = len_ff;
   assign rem_o   = rem_ff;
   assign q_o     = q_ff;
   assign neg_o   = neg_ff;
   assign degen_o = degen_ff;
endmodule
`default_nettype wire

FILE: src/triangle_unit_normal_unit.sv
// Top level: front end (edges, cross product, normalize), square root cells,
// divide cells, output saturation. Uses tun_pkg, tun_sqrt_cell, tun_div_cell.
// Stages: 5 front stages, 32 square root cells, a dividend register, 48 divide cells and
// an output register. Throughput: one triangle per cycle; the whole pipe advances when
// rsp_stall is low or the output register is empty. Reset clears the valid bits only.
`default_nettype none
module triangle_unit_normal_unit import tun_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CoordW-1:0] req_ax,
   input  wire logic [CoordW-1:0] req_ay,
   input  wire logic [CoordW-1:0] req_az,
   input  wire logic [CoordW-1:0] req_bx,
   input  wire logic [CoordW-1:0] req_by_coord,
   input  wire logic [CoordW-1:0] req_bz,
   input  wire logic [CoordW-1:0] req_cx,
   input  wire logic [CoordW-1:0] req_cy,
   input  wire logic [CoordW-1:0] req_cz,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [NormW-1:0]       rsp_nx,
   output logic [NormW-1:0]       rsp_ny,
   output logic [NormW-1:0]       rsp_nz,
   output logic                   rsp_degenerate
);
   localparam int DivDepth = DivSteps + RootW - 1;
   localparam int Depth = 5 + SqrtSteps + 1 + DivDepth + 1;

   logic adv;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;

   assign adv       = !(vld_ff[Depth-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Depth-1];

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // stage 1: edges
   logic signed [2:0][EdgeW-1:0] e1_ff, e2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff[0] <= $signed({req_bx[CoordW-1], req_bx}) - $signed({req_ax[CoordW-1], req_ax});
         e1_ff[1] <= $signed({req_by_coord[CoordW-1], req_by_coord})
                     - $signed({req_ay[CoordW-1], req_ay});
         e1_ff[2] <= $signed({req_bz[CoordW-1], req_bz}) - $signed({req_az[CoordW-1], req_az});
         e2_ff[0] <= $signed({req_cx[CoordW-1], req_cx}) - $signed({req_ax[CoordW-1], req_ax});
         e2_ff[1] <= $signed({req_cy[CoordW-1], req_cy}) - $signed({req_ay[CoordW-1], req_ay});
         e2_ff[2] <= $signed({req_cz[CoordW-1], req_cz}) - $signed({req_az[CoordW-1], req_az});
      end
   end

   // stage 2: six products
   logic signed [5:0][2*EdgeW-1:0] p_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= $signed(e1_ff[1]) * $signed(e2_ff[2]);
         p_ff[1] <= $signed(e1_ff[2]) * $signed(e2_ff[1]);
         p_ff[2] <= $signed(e1_ff[2]) * $signed(e2_ff[0]);
         p_ff[3] <= $signed(e1_ff[0]) * $signed(e2_ff[2]);
         p_ff[4] <= $signed(e1_ff[0]) * $signed(e2_ff[1]);
         p_ff[5] <= $signed(e1_ff[1]) * $signed(e2_ff[0]);
      end
   end

   // stage 3: cross product magnitudes and signs
   logic [2:0][CrossW-1:0] mag_ff;
   logic [2:0] sgn_ff;
   logic signed [2:0][CrossW:0] n_c;
   always_comb begin
      for (int i = 0; i < 3; i++)
         n_c[i] = $signed({p_ff[2*i][2*EdgeW-1], p_ff[2*i][2*EdgeW-1], p_ff[2*i]})
                - $signed({p_ff[2*i+1][2*EdgeW-1], p_ff[2*i+1][2*EdgeW-1], p_ff[2*i+1]});
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sgn_ff[i] <= n_c[i][CrossW];
            mag_ff[i] <= n_c[i][CrossW] ? CrossW'(-n_c[i]) : CrossW'(n_c[i]);
         end
      end
   end

   // stage 4: common shift so the largest lands in [2^30, 2^31)
   logic [CrossW-1:0] orv;
   logic [5:0] msb;
   logic [2:0][CrossW+MagW-1:0] ext;
   vec_type v_in;
   vec_type v_ff;
   always_comb begin
      orv = mag_ff[0] | mag_ff[1] | mag_ff[2];
      msb = '0;
      for (int b = 0; b < CrossW; b++) if (orv[b]) msb = 6'(b);
      v_in.neg   = sgn_ff;
      v_in.degen = (orv == '0);
      for (int i = 0; i < 3; i++) begin
         ext[i] = {mag_ff[i], {MagW{1'b0}}} >> msb;
         v_in.mag[i] = ext[i][MagW:1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) v_ff <= v_in;
   end

   // squares and sum fold into the first root stage input (one multiply each)
   logic [2:0][SumW-1:0] sq_ff;
   vec_type v2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) sq_ff[i] <= SumW'(v_ff.mag[i]) * SumW'(v_ff.mag[i]);
         v2_ff <= v_ff;
      end
   end

   // square root chain
   logic [SqrtSteps:0][SumW-1:0] s_rem, s_op;
   logic [SqrtSteps:0][RootW-1:0] s_root;
   vec_type s_vec [SqrtSteps+1];
   assign s_rem[0]  = '0;
   assign s_op[0]   = sq_ff[0] + sq_ff[1] + sq_ff[2];
   assign s_root[0] = '0;
   assign s_vec[0]  = v2_ff;

   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
      tun_sqrt_cell u_cell (
         .clock(clock), .en(adv),
         .rem_i(s_rem[g]), .op_i(s_op[g]), .root_i(s_root[g]), .vec_i(s_vec[g]),
         .rem_o(s_rem[g+1]), .op_o(s_op[g+1]), .root_o(s_root[g+1]), .vec_o(s_vec[g+1])
      );
   end

   // dividend (mag<<15) + len/2, below 2^47, fed MSB first
   localparam int DvdW = DivDepth;
   logic [RootW-1:0] len_ff;
   logic [2:0][DvdW-1:0] dvd_ff;
   logic [2:0] dneg_ff;
   logic ddeg_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff <= s_root[SqrtSteps];
         for (int i = 0; i < 3; i++)
            dvd_ff[i] <= DvdW'({s_vec[SqrtSteps].mag[i], 15'd0})
                       + DvdW'(s_root[SqrtSteps] >> 1);
         dneg_ff <= s_vec[SqrtSteps].neg;
         ddeg_ff <= s_vec[SqrtSteps].degen;
      end
   end

   // divide chain: quotient input MSB doubles as dividend shifter, fed the next dividend bit
   localparam int QW = DvdW;
   logic [DivDepth:0][RootW-1:0] d_len;
   logic [DivDepth:0][2:0][RootW:0] d_rem;
   logic [DivDepth:0][2:0][QuotW-1:0] d_q;
   logic [DivDepth:0][2:0] d_neg;
   logic [DivDepth:0] d_deg;
   logic [DivDepth:0][2:0][QW-1:0] d_src;

   assign d_len[0] = len_ff;
   assign d_rem[0] = '0;
   assign d_neg[0] = dneg_ff;
   assign d_deg[0] = ddeg_ff;
   assign d_src[0] = dvd_ff;
   assign d_q[0]   = '0;

   for (genvar g = 0; g < DivDepth; g++) begin : g_div
      logic [2:0][QuotW-1:0] qin;
      logic [2:0][QW-1:0] src_ff;
      always_comb begin
         for (int i = 0; i < 3; i++)
            qin[i] = {d_src[g][i][QW-1-g], d_q[g][i][QuotW-2:0]};
      end
      tun_div_cell u_cell (
         .clock(clock), .en(adv),
         .len_i(d_len[g]), .rem_i(d_rem[g]), .q_i(qin), .neg_i(d_neg[g]),
         .degen_i(d_deg[g]),
         .len_o(d_len[g+1]), .rem_o(d_rem[g+1]), .q_o(d_q[g+1]), .neg_o(d_neg[g+1]),
         .degen_o(d_deg[g+1])
      );
      always_ff @(posedge clock) begin
         if (adv) src_ff <= d_src[g];
      end
      assign d_src[g+1] = src_ff;
   end

   // cells pull the dividend MSB from bit QuotW-1 of qin: quotient shifts past it
   logic [2:0][QuotW-1:0] qf;
   logic [2:0][NormW-1:0] n_c2;
   assign qf = d_q[DivDepth];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (d_deg[DivDepth]) n_c2[i] = '0;
         else if (d_neg[DivDepth][i])
            n_c2[i] = (qf[i] > QuotW'(32768)) ? NormW'(16'h8000) : NormW'(-qf[i]);
         else
            n_c2[i] = (qf[i] > QuotW'(32767)) ? NormW'(16'h7fff) : NormW'(qf[i]);
      end
   end

   logic [2:0][NormW-1:0] out_ff;
   logic deg_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= n_c2;
         deg_ff <= d_deg[DivDepth];
      end
   end

   assign rsp_nx = out_ff[0];
   assign rsp_ny = out_ff[1];
   assign rsp_nz = out_ff[2];
   assign rsp_degenerate = deg_ff;
endmodule
`default_nettype wire
